>>> rtl/core/lspe_pkg.sv
// ----------------------------------------------------------------------------
// Light-state payload encoder package
// Shared types, field codes and arithmetic constants of the encoder.
// ----------------------------------------------------------------------------
package lspe_pkg;

  localparam int MAX_BYTES = 14;
  localparam int MIN_BYTES = 2;
  localparam int IDX_W     = 4;

  typedef logic [IDX_W-1:0] idx_t;

  // Positions of the presence flags in the request.
  localparam int P_ON       = 0;
  localparam int P_BRI      = 1;
  localparam int P_CT       = 2;
  localparam int P_XY       = 3;
  localparam int P_TIME     = 4;
  localparam int P_EFFECT   = 5;
  localparam int P_GRADIENT = 6;
  localparam int P_DURATION = 7;
  localparam int P_SPEED    = 8;

  localparam logic [7:0]  BRI_MAX     = 8'hFE;
  localparam logic [15:0] XY_MAX      = 16'd65279;
  localparam logic [15:0] XY_MIN      = 16'd1;
  localparam logic [15:0] TIME_MAX    = 16'hFFFE;
  localparam logic [16:0] SPEED_ONE   = 17'd65536;
  localparam logic [7:0]  SPEED_SCALE = 8'd254;
  localparam int          SPEED_SHIFT = 16;

  localparam logic [17:0] DUR_LIMIT = 18'd216000;
  localparam logic [17:0] DUR_MAX   = 18'd215999;
  localparam logic [17:0] TIER1_END = 18'd600;
  localparam logic [17:0] TIER2_END = 18'd3000;
  localparam logic [17:0] TIER3_END = 18'd9000;
  localparam logic [17:0] TIER4_END = 18'd36000;

  localparam logic [7:0] TIER1_BASE = 8'hFC;
  localparam logic [7:0] TIER2_BASE = 8'hCC;
  localparam logic [7:0] TIER3_BASE = 8'hA5;
  localparam logic [7:0] TIER4_BASE = 8'h79;
  localparam logic [7:0] TIER5_BASE = 8'h4A;

  // Division by a tier step is a multiplication by ceil(2^DIV_SHIFT / step).
  // With an 18-bit dividend and steps below 2^12 the quotient is exact.
  localparam int DIV_SHIFT = 30;
  localparam int RECIP_W   = 27;
  localparam int PROD_W    = 18 + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_10   = RECIP_W'((64'd1 << DIV_SHIFT) / 10 + 1);
  localparam logic [RECIP_W-1:0] RECIP_50   = RECIP_W'((64'd1 << DIV_SHIFT) / 50 + 1);
  localparam logic [RECIP_W-1:0] RECIP_150  = RECIP_W'((64'd1 << DIV_SHIFT) / 150 + 1);
  localparam logic [RECIP_W-1:0] RECIP_600  = RECIP_W'((64'd1 << DIV_SHIFT) / 600 + 1);
  localparam logic [RECIP_W-1:0] RECIP_3000 = RECIP_W'((64'd1 << DIV_SHIFT) / 3000 + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    idx_t                      len;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_port_t;

endpackage

>>> rtl/core/lspe_req_if.sv
// ----------------------------------------------------------------------------
// Light-state request channel
// Valid/ready channel that carries one light-state request per transaction.
// ----------------------------------------------------------------------------
interface lspe_req_if;
  logic        valid;
  logic        ready;
  logic [8:0]  present;
  logic        on_value;
  logic [7:0]  brightness;
  logic [15:0] color_temp;
  logic [15:0] color_x;
  logic [15:0] color_y;
  logic [15:0] transition_time;
  logic [7:0]  effect_code;
  logic [17:0] fx_duration;
  logic [16:0] fx_speed;

  modport source (
    output valid, present, on_value, brightness, color_temp, color_x, color_y,
           transition_time, effect_code, fx_duration, fx_speed,
    input  ready
  );

  modport sink (
    input  valid, present, on_value, brightness, color_temp, color_x, color_y,
           transition_time, effect_code, fx_duration, fx_speed,
    output ready
  );
endinterface

>>> rtl/core/lspe_byte_if.sv
// ----------------------------------------------------------------------------
// Payload byte channel
// Valid/ready channel that carries one payload byte per transaction.
// ----------------------------------------------------------------------------
interface lspe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

>>> rtl/core/light_state_payload_encoder_unit.sv
// ----------------------------------------------------------------------------
// Light-state payload encoder
// Turns one light-state request into a little-endian byte payload.
//
//   Channel  Role    Transaction
//   req      sink    one light-state request
//   pay      source  one payload byte, last_byte marks the end of a payload
//
// A request of N payload bytes (2 to 14) holds the byte port for all N bytes,
// one byte a cycle while pay.ready is high, each sent from an output register.
// Reset clears the valid flags, the queue pointers and the byte index.
// The queue holds two frames and the front stage one more, so the request
// port stalls only when all three are occupied by waiting frames.
// ----------------------------------------------------------------------------
module light_state_payload_encoder_unit (
  input logic         clk,
  input logic         rst,
  lspe_req_if.sink    req,
  lspe_byte_if.source pay
);

  lspe_pkg::q_port_t q_wr;
  lspe_pkg::q_port_t q_rd;
  logic              q_wr_ready;
  logic              q_pop;

  lspe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .wr       (q_wr),
    .wr_ready (q_wr_ready)
  );

  lspe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_ready (q_wr_ready),
    .rd       (q_rd),
    .pop      (q_pop)
  );

  lspe_back u_back (
    .clk (clk),
    .rst (rst),
    .rd  (q_rd),
    .pop (q_pop),
    .pay (pay)
  );

  a_reset_idle : assert property (@(posedge clk) rst |=> !pay.valid)
    else $error("byte output valid after reset");

  a_no_gap : assert property (@(posedge clk) disable iff (rst)
    (pay.valid && pay.ready && !pay.last_byte) |=> pay.valid)
    else $error("payload interrupted before its last byte");

  a_frame_len : assert property (@(posedge clk) disable iff (rst)
    q_rd.valid |-> (q_rd.frame.len >= lspe_pkg::idx_t'(lspe_pkg::MIN_BYTES)) &&
                   (q_rd.frame.len <= lspe_pkg::idx_t'(lspe_pkg::MAX_BYTES)))
    else $error("queued frame length out of range");

endmodule

>>> rtl/core/lspe_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts requests, clamps and codes the values, and packs the payload frame.
// ----------------------------------------------------------------------------
module lspe_front (
  input  logic             clk,
  input  logic             rst,
  lspe_req_if.sink         req,
  output lspe_pkg::q_port_t wr,
  input  logic             wr_ready
);

  logic                          v1;
  logic [8:0]                    p1;
  logic                          on1;
  logic [7:0]                    bri1;
  logic [15:0]                   ct1;
  logic [15:0]                   x1;
  logic [15:0]                   y1;
  logic [15:0]                   tt1;
  logic [7:0]                    eff1;
  logic                          dzero1;
  logic [7:0]                    dbase1;
  logic [7:0]                    dq1;
  logic [7:0]                    spd1;

  logic                          adv;
  logic [17:0]                   d_sat;
  logic [lspe_pkg::RECIP_W-1:0]  recip;
  logic [7:0]                    base;
  logic [lspe_pkg::PROD_W-1:0]   dprod;
  logic [16:0]                   s_sat;
  logic [24:0]                   sprod;
  lspe_pkg::frame_t              f;
  lspe_pkg::idx_t                pos;

  function automatic logic [15:0] clamp_xy(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (v > lspe_pkg::XY_MAX) begin
      r = lspe_pkg::XY_MAX;
    end else if (v == '0) begin
      r = lspe_pkg::XY_MIN;
    end
    return r;
  endfunction

  assign adv       = !v1 || wr_ready;
  assign req.ready = adv;

  always_comb begin
    d_sat = (req.fx_duration >= lspe_pkg::DUR_LIMIT) ? lspe_pkg::DUR_MAX
                                                     : req.fx_duration;
    if (d_sat < lspe_pkg::TIER1_END) begin
      recip = lspe_pkg::RECIP_10;
      base  = lspe_pkg::TIER1_BASE;
    end else if (d_sat < lspe_pkg::TIER2_END) begin
      recip = lspe_pkg::RECIP_50;
      base  = lspe_pkg::TIER2_BASE;
    end else if (d_sat < lspe_pkg::TIER3_END) begin
      recip = lspe_pkg::RECIP_150;
      base  = lspe_pkg::TIER3_BASE;
    end else if (d_sat < lspe_pkg::TIER4_END) begin
      recip = lspe_pkg::RECIP_600;
      base  = lspe_pkg::TIER4_BASE;
    end else begin
      recip = lspe_pkg::RECIP_3000;
      base  = lspe_pkg::TIER5_BASE;
    end
    dprod = lspe_pkg::PROD_W'(d_sat) * lspe_pkg::PROD_W'(recip);
    s_sat = (req.fx_speed > lspe_pkg::SPEED_ONE) ? lspe_pkg::SPEED_ONE
                                                 : req.fx_speed;
    sprod = 25'(s_sat) * 25'(lspe_pkg::SPEED_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req.valid) begin
      p1     <= req.present;
      on1    <= req.on_value;
      bri1   <= (req.brightness > lspe_pkg::BRI_MAX) ? lspe_pkg::BRI_MAX : req.brightness;
      ct1    <= req.color_temp;
      x1     <= clamp_xy(req.color_x);
      y1     <= clamp_xy(req.color_y);
      tt1    <= (req.transition_time > lspe_pkg::TIME_MAX) ? lspe_pkg::TIME_MAX
                                                           : req.transition_time;
      eff1   <= req.effect_code;
      dzero1 <= (d_sat == '0);
      dbase1 <= base;
      dq1    <= dprod[lspe_pkg::DIV_SHIFT +: 8];
      spd1   <= sprod[lspe_pkg::SPEED_SHIFT +: 8];
    end
  end

  always_comb begin
    f = '0;
    f.data[0] = {p1[lspe_pkg::P_DURATION] | p1[lspe_pkg::P_SPEED], p1[6:0]};
    f.data[1] = 8'h00;
    pos = lspe_pkg::idx_t'(lspe_pkg::MIN_BYTES);
    if (p1[lspe_pkg::P_ON]) begin
      f.data[pos] = {7'd0, on1};
      pos = pos + lspe_pkg::idx_t'(1);
    end
    if (p1[lspe_pkg::P_BRI]) begin
      f.data[pos] = bri1;
      pos = pos + lspe_pkg::idx_t'(1);
    end
    if (p1[lspe_pkg::P_CT]) begin
      f.data[pos] = ct1[7:0];
      f.data[pos + lspe_pkg::idx_t'(1)] = ct1[15:8];
      pos = pos + lspe_pkg::idx_t'(2);
    end
    if (p1[lspe_pkg::P_XY]) begin
      f.data[pos] = x1[7:0];
      f.data[pos + lspe_pkg::idx_t'(1)] = x1[15:8];
      f.data[pos + lspe_pkg::idx_t'(2)] = y1[7:0];
      f.data[pos + lspe_pkg::idx_t'(3)] = y1[15:8];
      pos = pos + lspe_pkg::idx_t'(4);
    end
    if (p1[lspe_pkg::P_TIME]) begin
      f.data[pos] = tt1[7:0];
      f.data[pos + lspe_pkg::idx_t'(1)] = tt1[15:8];
      pos = pos + lspe_pkg::idx_t'(2);
    end
    if (p1[lspe_pkg::P_EFFECT]) begin
      f.data[pos] = eff1;
      pos = pos + lspe_pkg::idx_t'(1);
    end
    if (p1[lspe_pkg::P_DURATION]) begin
      f.data[pos] = dzero1 ? 8'h00 : (dbase1 - dq1);
      pos = pos + lspe_pkg::idx_t'(1);
    end else if (p1[lspe_pkg::P_SPEED]) begin
      f.data[pos] = spd1;
      pos = pos + lspe_pkg::idx_t'(1);
    end
    f.len = pos;
  end

  assign wr.valid = v1;
  assign wr.frame = f;

endmodule

>>> rtl/core/lspe_queue.sv
// ----------------------------------------------------------------------------
// Encoder frame queue
// Two-entry queue of packed payload frames between front end and back end.
// ----------------------------------------------------------------------------
module lspe_queue (
  input  logic              clk,
  input  logic              rst,
  input  lspe_pkg::q_port_t wr,
  output logic              wr_ready,
  output lspe_pkg::q_port_t rd,
  input  logic              pop
);

  lspe_pkg::frame_t              mem [lspe_pkg::QDEPTH];
  logic [lspe_pkg::QPTR_W-1:0]   wp;
  logic [lspe_pkg::QPTR_W-1:0]   rp;
  logic [lspe_pkg::QCNT_W-1:0]   cnt;
  logic                          push;

  assign wr_ready = (cnt != lspe_pkg::QCNT_W'(lspe_pkg::QDEPTH));
  assign push     = wr.valid && wr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + lspe_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rp <= rp + lspe_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + lspe_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - lspe_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr.frame;
    end
  end

  assign rd.valid = (cnt != '0);
  assign rd.frame = mem[rp];

endmodule

>>> rtl/core/lspe_back.sv
// ----------------------------------------------------------------------------
// Encoder back end
// Streams the head frame of the queue out one byte per transaction.
// ----------------------------------------------------------------------------
module lspe_back (
  input  logic              clk,
  input  logic              rst,
  input  lspe_pkg::q_port_t rd,
  output logic              pop,
  lspe_byte_if.source       pay
);

  lspe_pkg::idx_t idx;
  logic           ovalid;
  logic [7:0]     obyte;
  logic           olast;
  logic           load;
  logic           last;

  assign load = rd.valid && (!ovalid || pay.ready);
  assign last = (idx == (rd.frame.len - lspe_pkg::idx_t'(1)));
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= last ? '0 : idx + lspe_pkg::idx_t'(1);
      end else if (pay.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= rd.frame.data[idx];
      olast <= last;
    end
  end

  assign pay.valid     = ovalid;
  assign pay.out_byte  = obyte;
  assign pay.last_byte = olast;

endmodule
